@@ src/ttqs_pkg.sv @@
package ttqs_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 32;
   localparam int LEFT_W = 6;

   // request functions
   typedef enum logic [1:0] {
      FUNC_ENQ    = 2'd0,
      FUNC_TAKE   = 2'd1,
      FUNC_CANCEL = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // tiers
   localparam logic [1:0] TIER_BG     = 2'd0;
   localparam logic [1:0] TIER_HIGH   = 2'd1;
   localparam logic [1:0] TIER_VIEWER = 2'd2;

   // placement rules
   localparam logic [2:0] RULE_BAND     = 3'd0;
   localparam logic [2:0] RULE_STAGE    = 3'd1;
   localparam logic [2:0] RULE_BGFRONT  = 3'd2;
   localparam logic [2:0] RULE_STOPKIND = 3'd3;
   localparam logic [2:0] RULE_TAIL     = 3'd4;

   // result status
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;

   // register indexes
   localparam logic CSR_READ_MASK   = 1'b0;
   localparam logic CSR_DECODE_MASK = 1'b1;

   // scan phases
   localparam logic [1:0] PH_FIRST = 2'd0;
   localparam logic [1:0] PH_LOWER = 2'd1;
   localparam logic [1:0] PH_EQUAL = 2'd2;

   typedef struct packed {
      logic [15:0] handle;
      logic [1:0]  tier;
      logic [31:0] generation;
      logic [7:0]  ordinal;
      logic [2:0]  kind;
   } entry_type;

   typedef struct packed {
      func_type   func;
      entry_type  ent;
      logic [2:0] rule;
      logic [7:0] stops;
      logic       want;
      logic       vonly;
   } op_type;

   typedef struct packed {
      logic       stop;
      logic [1:0] phase;
   } scan_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_INS,
      S_INSW,
      S_DEL,
      S_CANCEL,
      S_EMIT
   } state_type;

endpackage

@@ src/ttqs_scan.sv @@
module ttqs_scan (
   input  ttqs_pkg::op_type    op,
   input  ttqs_pkg::entry_type entry,
   input  logic [1:0]          phase,
   input  logic [7:0]          read_mask,
   output ttqs_pkg::scan_type  res
);

   logic is_v;
   logic gt;
   logic lt;
   logic eq;
   logic with_eq;

   // viewer ordering compares
   assign is_v    = (entry.tier == ttqs_pkg::TIER_VIEWER);
   assign gt      = is_v && (entry.generation > op.ent.generation);
   assign lt      = is_v && (entry.generation == op.ent.generation)
                    && (entry.ordinal < op.ent.ordinal);
   assign eq      = is_v && (entry.generation == op.ent.generation)
                    && (entry.ordinal == op.ent.ordinal);
   assign with_eq = (op.rule == ttqs_pkg::RULE_BAND);

   // stop decision for one entry
   always_comb begin
      res.stop  = 1'b0;
      res.phase = phase;
      if (op.func == ttqs_pkg::FUNC_TAKE) begin
         res.stop = (read_mask[entry.kind] == op.want);
      end else begin
         case (op.rule) inside
            ttqs_pkg::RULE_BAND, ttqs_pkg::RULE_STAGE: begin
               if (op.rule == ttqs_pkg::RULE_STAGE || op.ent.tier == ttqs_pkg::TIER_VIEWER) begin
                  case (phase)
                     ttqs_pkg::PH_FIRST: begin
                        if (gt) begin
                           res.stop = 1'b0;
                        end else if (lt) begin
                           res.phase = ttqs_pkg::PH_LOWER;
                        end else if (eq && with_eq) begin
                           res.phase = ttqs_pkg::PH_EQUAL;
                        end else begin
                           res.stop = 1'b1;
                        end
                     end
                     ttqs_pkg::PH_LOWER: begin
                        if (lt) begin
                           res.stop = 1'b0;
                        end else if (eq && with_eq) begin
                           res.phase = ttqs_pkg::PH_EQUAL;
                        end else begin
                           res.stop = 1'b1;
                        end
                     end
                     default: res.stop = !eq;
                  endcase
               end else begin
                  res.stop = (entry.tier < op.ent.tier);
               end
            end
            ttqs_pkg::RULE_BGFRONT: res.stop = (entry.tier == ttqs_pkg::TIER_BG);
            ttqs_pkg::RULE_STOPKIND: begin
               if (phase == ttqs_pkg::PH_FIRST && entry.tier != ttqs_pkg::TIER_BG) begin
                  res.stop = 1'b0;
               end else begin
                  res.phase = ttqs_pkg::PH_LOWER;
                  res.stop  = op.stops[entry.kind];
               end
            end
            default: res.stop = 1'b0;
         endcase
      end
   end

endmodule

@@ src/tiered_task_queue_scheduler_top.sv @@
// Ordered task queue held in one synchronous memory. Each request is worked
// one at a time by a sequencer that walks the memory one entry per cycle
// (a cancel holds while the result side stalls): an enqueue scans for its
// place and then shifts the entries behind it down, a take scans for the
// first matching entry and shifts the rest up, and a cancel compacts the
// queue in a single pass while reporting each removed task. An enqueue with
// the tail rule skips the scan. The memory has a single port pair, one read
// and one write a cycle. A full queue or an unknown function answers with
// no scan.
module tiered_task_queue_scheduler_top #(
   parameter int QUEUE_DEPTH = ttqs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_task_handle,
   input  logic [1:0]  req_tier,
   input  logic [31:0] req_generation,
   input  logic [7:0]  req_ordinal,
   input  logic [2:0]  req_kind,
   input  logic [2:0]  req_place_rule,
   input  logic [7:0]  req_stop_kinds,
   input  logic        req_worker_is_read,
   input  logic        req_viewer_only,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_handle,
   output logic        rsp_out_is_viewer,
   output logic [ttqs_pkg::LEFT_W-1:0] rsp_entries_left,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int LW = ttqs_pkg::LEFT_W;

   ttqs_pkg::entry_type mem [QUEUE_DEPTH];

   ttqs_pkg::state_type state_ff, state_in;
   ttqs_pkg::op_type    op_ff, op_in, req_op;
   ttqs_pkg::entry_type rd_data_ff;
   ttqs_pkg::scan_type  scan;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] tot_ff, tot_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] w_ff, w_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] j_inc, j_dec, cnt_dec;
   logic [1:0]    phase_ff, phase_in;
   logic          hold_ff, hold_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [15:0]   res_handle_ff, res_handle_in;
   logic          res_viewer_ff, res_viewer_in;
   logic [LW-1:0] res_left_ff, res_left_in;
   logic [7:0]    read_mask_ff, decode_mask_ff;

   logic          rd_en, wr_en;
   logic [IW-1:0] rd_addr, wr_addr;
   ttqs_pkg::entry_type wr_data;

   logic          out_free, out_load, out_last;
   logic          rem;

   // request capture, tier 3 folds into viewer
   always_comb begin
      req_op.func           = ttqs_pkg::func_type'(req_func);
      req_op.ent.handle     = req_task_handle;
      req_op.ent.tier       = (req_tier == 2'd3) ? ttqs_pkg::TIER_VIEWER : req_tier;
      req_op.ent.generation = req_generation;
      req_op.ent.ordinal    = req_ordinal;
      req_op.ent.kind       = req_kind;
      req_op.rule           = req_place_rule;
      req_op.stops          = req_stop_kinds;
      req_op.want           = req_worker_is_read;
      req_op.vonly          = req_viewer_only;
   end

   ttqs_scan u_scan (
      .op        (op_ff),
      .entry     (rd_data_ff),
      .phase     (phase_ff),
      .read_mask (read_mask_ff),
      .res       (scan)
   );

   assign j_inc    = j_ff + 1'b1;
   assign j_dec    = j_ff - 1'b1;
   assign cnt_dec  = count_ff - 1'b1;
   assign out_free = !rsp_valid || rsp_ready;
   assign rem      = decode_mask_ff[rd_data_ff.kind]
                     && (!op_ff.vonly || rd_data_ff.tier == ttqs_pkg::TIER_VIEWER);
   assign req_ready = (state_ff == ttqs_pkg::S_IDLE);
   assign csr_ready = 1'b1;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      tot_in        = tot_ff;
      j_in          = j_ff;
      w_in          = w_ff;
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      hold_in       = hold_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_viewer_in = res_viewer_ff;
      res_left_in   = res_left_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data_ff;
      out_load      = 1'b0;
      out_last      = 1'b1;
      unique case (state_ff)
         ttqs_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in         = req_op;
               j_in          = '0;
               w_in          = '0;
               tot_in        = count_ff;
               phase_in      = ttqs_pkg::PH_FIRST;
               hold_in       = 1'b0;
               rd_en         = 1'b1;
               res_status_in = ttqs_pkg::ST_NONE;
               res_handle_in = '0;
               res_viewer_in = 1'b0;
               res_left_in   = LW'(count_ff);
               unique case (req_op.func)
                  ttqs_pkg::FUNC_ENQ: begin
                     if (count_ff >= CW'(QUEUE_DEPTH)) begin
                        res_status_in = ttqs_pkg::ST_FULL;
                        state_in      = ttqs_pkg::S_EMIT;
                     end else if (req_op.rule >= ttqs_pkg::RULE_TAIL) begin
                        pos_in   = count_ff;
                        state_in = ttqs_pkg::S_INSW;
                     end else begin
                        state_in = ttqs_pkg::S_SCAN;
                     end
                  end
                  ttqs_pkg::FUNC_TAKE:   state_in = ttqs_pkg::S_SCAN;
                  ttqs_pkg::FUNC_CANCEL: state_in = ttqs_pkg::S_CANCEL;
                  default:               state_in = ttqs_pkg::S_EMIT;
               endcase
            end
         end
         ttqs_pkg::S_SCAN: begin
            if (j_ff >= count_ff || scan.stop) begin
               if (op_ff.func == ttqs_pkg::FUNC_TAKE) begin
                  if (j_ff < count_ff) begin
                     res_status_in = ttqs_pkg::ST_DONE;
                     res_handle_in = rd_data_ff.handle;
                     res_viewer_in = (rd_data_ff.tier == ttqs_pkg::TIER_VIEWER);
                     j_in          = j_inc;
                     rd_en         = 1'b1;
                     rd_addr       = j_inc[IW-1:0];
                     state_in      = ttqs_pkg::S_DEL;
                  end else begin
                     state_in = ttqs_pkg::S_EMIT;
                  end
               end else begin
                  pos_in = j_ff;
                  if (j_ff == count_ff) begin
                     state_in = ttqs_pkg::S_INSW;
                  end else begin
                     j_in     = cnt_dec;
                     rd_en    = 1'b1;
                     rd_addr  = cnt_dec[IW-1:0];
                     state_in = ttqs_pkg::S_INS;
                  end
               end
            end else begin
               phase_in = scan.phase;
               j_in     = j_inc;
               rd_en    = 1'b1;
               rd_addr  = j_inc[IW-1:0];
            end
         end
         // shift entries down, from the tail to the insert point
         ttqs_pkg::S_INS: begin
            wr_en   = 1'b1;
            wr_addr = j_inc[IW-1:0];
            if (j_ff == pos_ff) begin
               state_in = ttqs_pkg::S_INSW;
            end else begin
               j_in    = j_dec;
               rd_en   = 1'b1;
               rd_addr = j_dec[IW-1:0];
            end
         end
         ttqs_pkg::S_INSW: begin
            wr_en         = 1'b1;
            wr_addr       = pos_ff[IW-1:0];
            wr_data       = op_ff.ent;
            count_in      = count_ff + 1'b1;
            res_status_in = ttqs_pkg::ST_DONE;
            res_handle_in = '0;
            res_viewer_in = 1'b0;
            res_left_in   = LW'(count_ff + 1'b1);
            state_in      = ttqs_pkg::S_EMIT;
         end
         // shift entries up over the taken one
         ttqs_pkg::S_DEL: begin
            if (j_ff >= count_ff) begin
               count_in    = cnt_dec;
               res_left_in = LW'(cnt_dec);
               state_in    = ttqs_pkg::S_EMIT;
            end else begin
               wr_en   = 1'b1;
               wr_addr = j_dec[IW-1:0];
               j_in    = j_inc;
               rd_en   = 1'b1;
               rd_addr = j_inc[IW-1:0];
            end
         end
         // compact in one pass, report each removed task
         ttqs_pkg::S_CANCEL: begin
            if (j_ff >= tot_ff) begin
               if (!hold_ff) begin
                  res_status_in = ttqs_pkg::ST_NONE;
                  res_handle_in = '0;
                  res_viewer_in = 1'b0;
                  res_left_in   = LW'(count_ff);
               end
               state_in = ttqs_pkg::S_EMIT;
            end else if (rem) begin
               if (!hold_ff || out_free) begin
                  out_load      = hold_ff;
                  out_last      = 1'b0;
                  res_status_in = ttqs_pkg::ST_DONE;
                  res_handle_in = rd_data_ff.handle;
                  res_viewer_in = (rd_data_ff.tier == ttqs_pkg::TIER_VIEWER);
                  res_left_in   = LW'(cnt_dec);
                  count_in      = cnt_dec;
                  hold_in       = 1'b1;
                  j_in          = j_inc;
                  rd_en         = 1'b1;
                  rd_addr       = j_inc[IW-1:0];
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = w_ff[IW-1:0];
               w_in    = w_ff + 1'b1;
               j_in    = j_inc;
               rd_en   = 1'b1;
               rd_addr = j_inc[IW-1:0];
            end
         end
         ttqs_pkg::S_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ttqs_pkg::S_IDLE;
            end
         end
         default: state_in = ttqs_pkg::S_IDLE;
      endcase
   end

   // queue memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ttqs_pkg::S_IDLE;
         count_ff       <= '0;
         hold_ff        <= 1'b0;
         read_mask_ff   <= 8'd3;
         decode_mask_ff <= 8'd74;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         hold_ff  <= hold_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == ttqs_pkg::CSR_READ_MASK) begin
               read_mask_ff <= csr_data;
            end
            if (csr_index == ttqs_pkg::CSR_DECODE_MASK) begin
               decode_mask_ff <= csr_data;
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tot_ff        <= tot_in;
      j_ff          <= j_in;
      w_ff          <= w_in;
      pos_ff        <= pos_in;
      phase_ff      <= phase_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_viewer_ff <= res_viewer_in;
      res_left_ff   <= res_left_in;
   end

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (out_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status        <= res_status_ff;
         rsp_out_handle    <= res_handle_ff;
         rsp_out_is_viewer <= res_viewer_ff;
         rsp_entries_left  <= res_left_ff;
         rsp_last          <= out_last;
      end
   end

endmodule
